FILE: sv/hlfv_pkg.sv
// Package for the frame validator: phase codes, verdict codes, transfer
// structs and constant character tables. No dependencies.
package hlfv_pkg;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_METHOD = 4'd1,
        PH_PATH   = 4'd2,
        PH_RVER   = 4'd3,
        PH_SVER   = 4'd4,
        PH_SSP    = 4'd5,
        PH_STATUS = 4'd6,
        PH_REASON = 4'd7,
        PH_KEY    = 4'd8,
        PH_COLON  = 4'd9,
        PH_VALUE  = 4'd10,
        PH_SKIP   = 4'd11,
        PH_BODY   = 4'd12,
        PH_DONE   = 4'd13
    } phase_t;

    localparam logic [1:0] V_OK   = 2'd0;
    localparam logic [1:0] V_MAL  = 2'd1;
    localparam logic [1:0] V_LONG = 2'd2;
    localparam logic [1:0] V_LEN  = 2'd3;

    localparam logic [2:0] REG_MAX_LINES  = 3'd0;
    localparam logic [2:0] REG_KEY_CAP    = 3'd1;
    localparam logic [2:0] REG_VALUE_CAP  = 3'd2;
    localparam logic [2:0] REG_METHOD_CAP = 3'd3;
    localparam logic [2:0] REG_PATH_CAP   = 3'd4;

    localparam logic [10:0] TOK_MAX   = 11'd2047;
    localparam logic [3:0]  NAME_LEN  = 4'd14;
    localparam logic [3:0]  NAME_MISS = 4'd15;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;

    // byte classification made by the front end
    typedef struct packed {
        logic [7:0] low;     // byte, folded to lower case
        logic [7:0] raw;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_sp;
        logic       is_colon;
        logic       is_nul;
        logic       is_cr;
        logic       is_lf;
    } class_t;

    typedef struct packed {
        class_t cls;
        logic   mode;
        logic   last;
    } item_t;

    typedef struct packed {
        logic [5:0]  max_lines;
        logic [7:0]  key_cap;
        logic [9:0]  value_cap;
        logic [5:0]  method_cap;
        logic [9:0]  path_cap;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        kind;
        logic        prev_cr;
        logic [10:0] tlen;
        logic [10:0] t2len;
        logic        nul;
        logic [4:0]  vidx;
        logic [1:0]  lpe;
        logic [1:0]  ferr;
        logic [5:0]  acc;
        logic [3:0]  nidx;
        logic        lseen;
        logic [31:0] dlen;
        logic [5:0]  ddig;
        logic        dbad;
        logic [9:0]  stat;
        logic        stok;
    } st_t;

    localparam st_t ST_CLEAR = '{phase: PH_START, default: '0};

    localparam class_t CLS_CR = '{low: CH_CR, raw: CH_CR, digit: 4'd0, is_digit: 1'b0,
                                  is_sp: 1'b0, is_colon: 1'b0, is_nul: 1'b0,
                                  is_cr: 1'b1, is_lf: 1'b0};

    function automatic logic [7:0] ver_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0: c = "H";
            4'd1: c = "T";
            4'd2: c = "T";
            4'd3: c = "T";
            4'd4: c = "P";
            4'd5: c = "/";
            4'd6: c = "1";
            4'd7: c = ".";
            4'd8: c = "0";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0: c = "c";
            4'd1: c = "o";
            4'd2: c = "n";
            4'd3: c = "t";
            4'd4: c = "e";
            4'd5: c = "n";
            4'd6: c = "t";
            4'd7: c = "-";
            4'd8: c = "l";
            4'd9: c = "e";
            4'd10: c = "n";
            4'd11: c = "g";
            4'd12: c = "t";
            4'd13: c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/http_like_frame_validator_top.sv
// Top level of the frame validator: configuration registers, front end
// queue and parser back end. Uses hlfv_pkg, hlfv_front, hlfv_back.
//
// The block takes one frame byte per cycle on the s_ stream and gives one
// result transfer on the m_ stream for the byte marked by s_tlast. Each
// byte passes a classifier and a two-entry queue, then the parser updates
// its running state, so bytes flow back to back. With the queue empty, the
// last byte is stored in the queue and its result is then registered in
// the output register that drives m_tvalid. While a result is held there
// with m_tready low the parser takes no byte, so a stalled m_ stream backs
// up into the queue and then into s_tready. Configuration writes are always
// ready and take effect on the next byte the parser takes.
module http_like_frame_validator_top #(
    parameter int FRAME_BYTES   = 65536,
    parameter int VERSION_BYTES = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] verdict, [7:2] header_lines, [24:8] body_offset,
    // [41:25] body_length, [51:42] status_number, [55:52] zero
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    hlfv_pkg::cfg_t  cfg_reg, cfg_next;
    hlfv_pkg::item_t q_item;
    logic            q_valid, q_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_index[7:3] == 5'd0) begin
            unique case (cfg_index[2:0])
                hlfv_pkg::REG_MAX_LINES:  cfg_next.max_lines  = cfg_data[5:0];
                hlfv_pkg::REG_KEY_CAP:    cfg_next.key_cap    = cfg_data[7:0];
                hlfv_pkg::REG_VALUE_CAP:  cfg_next.value_cap  = cfg_data;
                hlfv_pkg::REG_METHOD_CAP: cfg_next.method_cap = cfg_data[5:0];
                hlfv_pkg::REG_PATH_CAP:   cfg_next.path_cap   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_lines  <= 6'd16;
            cfg_reg.key_cap    <= 8'd64;
            cfg_reg.value_cap  <= 10'd256;
            cfg_reg.method_cap <= 6'd16;
            cfg_reg.path_cap   <= 10'd256;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hlfv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    hlfv_back #(
        .FRAME_BYTES   (FRAME_BYTES),
        .VERSION_BYTES (VERSION_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: sv/hlfv_front.sv
// Front end: accepts input transfers, classifies each byte and holds the
// items in a two-entry queue for the parser. Uses hlfv_pkg.
module hlfv_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              s_tlast,
    output logic              q_valid,
    input  logic              q_ready,
    output hlfv_pkg::item_t   q_item
);

    hlfv_pkg::item_t mem_reg [2];
    hlfv_pkg::item_t in_item;
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb begin
        in_item.cls.raw      = s_tdata;
        in_item.cls.low      = (s_tdata >= "A" && s_tdata <= "Z") ? s_tdata + 8'd32 : s_tdata;
        in_item.cls.is_digit = (s_tdata >= "0" && s_tdata <= "9");
        in_item.cls.digit    = s_tdata[3:0];
        in_item.cls.is_sp    = (s_tdata == " ");
        in_item.cls.is_colon = (s_tdata == ":");
        in_item.cls.is_nul   = (s_tdata == 8'h00);
        in_item.cls.is_cr    = (s_tdata == hlfv_pkg::CH_CR);
        in_item.cls.is_lf    = (s_tdata == hlfv_pkg::CH_LF);
        in_item.mode         = s_tuser;
        in_item.last         = s_tlast;
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push) else $error("push into full queue");
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (rptr_reg != $past(rptr_reg))) else $error("read pointer stuck");

endmodule

FILE: sv/hlfv_back.sv
// Back end: per-byte parser state, verdict logic and the result register.
// Takes classified items from hlfv_front. Uses hlfv_pkg.
module hlfv_back #(
    parameter int FRAME_BYTES   = 65536,
    parameter int VERSION_BYTES = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hlfv_pkg::cfg_t    cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  hlfv_pkg::item_t   q_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata
);

    localparam int POS_W = $clog2(FRAME_BYTES + 2);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_BYTES);
    localparam logic [4:0] VER_N = 5'(VERSION_BYTES);

    hlfv_pkg::st_t st_reg, st_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] bs_reg, bs_next;
    logic        out_valid_reg, out_valid_next;
    logic [55:0] out_data_reg, out_data_next;
    logic        take;

    function automatic logic line_ph(input hlfv_pkg::st_t s);
        return s.phase != hlfv_pkg::PH_BODY && s.phase != hlfv_pkg::PH_DONE;
    endfunction

    function automatic logic [10:0] tinc(input logic [10:0] v);
        return (v < hlfv_pkg::TOK_MAX) ? v + 11'd1 : v;
    endfunction

    function automatic hlfv_pkg::st_t content(input hlfv_pkg::st_t si,
                                              input hlfv_pkg::class_t c,
                                              input hlfv_pkg::cfg_t k);
        hlfv_pkg::st_t s;
        logic [10:0] cap;
        logic [12:0] sv;
        logic [35:0] n;
        logic        cl;
        s  = si;
        cap = (si.phase == hlfv_pkg::PH_METHOD) ? {5'd0, k.method_cap} : {1'b0, k.path_cap};
        sv = {3'd0, si.stat} * 13'd10 + {9'd0, c.digit};
        n  = {1'b0, si.dlen, 3'd0} + {3'd0, si.dlen, 1'b0} + {32'd0, c.digit};
        cl = (si.nidx == hlfv_pkg::NAME_LEN) && !si.lseen;
        unique case (si.phase)
            hlfv_pkg::PH_METHOD, hlfv_pkg::PH_PATH: begin
                if (c.is_sp) begin
                    if (si.tlen == 11'd0) begin
                        s.lpe = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_SKIP;
                    end else if (si.tlen >= cap || si.nul) begin
                        s.lpe = hlfv_pkg::V_LONG; s.phase = hlfv_pkg::PH_SKIP;
                    end else begin
                        if (si.phase == hlfv_pkg::PH_METHOD) begin
                            s.phase = hlfv_pkg::PH_PATH;
                        end else begin
                            s.phase = hlfv_pkg::PH_RVER;
                            s.vidx  = 5'd0;
                        end
                        s.tlen = 11'd0;
                        s.nul  = 1'b0;
                    end
                end else begin
                    s.tlen = tinc(si.tlen);
                    s.nul  = si.nul | c.is_nul;
                end
            end
            hlfv_pkg::PH_RVER, hlfv_pkg::PH_SVER: begin
                if (si.vidx < VER_N && c.raw == hlfv_pkg::ver_char(si.vidx[3:0])) begin
                    s.vidx = si.vidx + 5'd1;
                    if (si.phase == hlfv_pkg::PH_SVER && s.vidx == VER_N) begin
                        s.phase = hlfv_pkg::PH_SSP;
                    end
                end else begin
                    s.lpe = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_SKIP;
                end
            end
            hlfv_pkg::PH_SSP: begin
                if (c.is_sp) begin
                    s.phase = hlfv_pkg::PH_STATUS; s.tlen = 11'd0; s.stat = 10'd0;
                end else begin
                    s.lpe = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_SKIP;
                end
            end
            hlfv_pkg::PH_STATUS: begin
                if (c.is_sp) begin
                    if (si.tlen == 11'd0 || si.tlen > 11'd32 || si.stat < 10'd100
                        || si.stat > 10'd599) begin
                        s.lpe = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_SKIP;
                    end else begin
                        s.phase = hlfv_pkg::PH_REASON;
                    end
                end else if (c.is_digit) begin
                    s.tlen = tinc(si.tlen);
                    s.stat = (sv > 13'd600) ? 10'd600 : sv[9:0];
                end else begin
                    s.lpe = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_SKIP;
                end
            end
            hlfv_pkg::PH_KEY: begin
                if (c.is_colon) begin
                    if (si.tlen == 11'd0) begin
                        s.lpe = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_SKIP;
                    end else begin
                        priority if (si.acc >= k.max_lines) s.lpe = hlfv_pkg::V_LONG;
                        else if (si.tlen >= {3'd0, k.key_cap}) s.lpe = hlfv_pkg::V_LONG;
                        else if (si.nul) s.lpe = hlfv_pkg::V_MAL;
                        else s.lpe = hlfv_pkg::V_OK;
                        s.phase = hlfv_pkg::PH_COLON;
                    end
                end else begin
                    s.tlen = tinc(si.tlen);
                    s.nul  = si.nul | c.is_nul;
                    if (si.nidx < hlfv_pkg::NAME_LEN && c.low == hlfv_pkg::name_char(si.nidx)) begin
                        s.nidx = si.nidx + 4'd1;
                    end else begin
                        s.nidx = hlfv_pkg::NAME_MISS;
                    end
                end
            end
            hlfv_pkg::PH_COLON: begin
                if (!c.is_sp) begin
                    s.lpe = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_SKIP;
                end else if (si.lpe != hlfv_pkg::V_OK) begin
                    s.phase = hlfv_pkg::PH_SKIP;
                end else begin
                    s.phase = hlfv_pkg::PH_VALUE; s.t2len = 11'd0; s.nul = 1'b0;
                    if (cl) begin
                        s.dlen = 32'd0; s.ddig = 6'd0; s.dbad = 1'b0;
                    end
                end
            end
            hlfv_pkg::PH_VALUE: begin
                s.t2len = tinc(si.t2len);
                s.nul   = si.nul | c.is_nul;
                if (cl) begin
                    if (si.ddig < 6'd33) s.ddig = si.ddig + 6'd1;
                    if (!c.is_digit) begin
                        s.dbad = 1'b1;
                    end else if (!si.dbad) begin
                        if (n[35:32] != 4'd0) s.dbad = 1'b1;
                        else s.dlen = n[31:0];
                    end
                end
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    function automatic hlfv_pkg::st_t hdr_start(input hlfv_pkg::st_t si);
        hlfv_pkg::st_t s;
        s = si;
        s.phase = hlfv_pkg::PH_KEY; s.tlen = 11'd0; s.t2len = 11'd0; s.nul = 1'b0;
        s.nidx = 4'd0; s.lpe = hlfv_pkg::V_OK;
        return s;
    endfunction

    function automatic hlfv_pkg::st_t line_end(input hlfv_pkg::st_t si,
                                               input hlfv_pkg::cfg_t k);
        hlfv_pkg::st_t s;
        s = si;
        unique case (si.phase)
            hlfv_pkg::PH_SKIP: begin
                s.ferr = si.lpe; s.phase = hlfv_pkg::PH_DONE;
            end
            hlfv_pkg::PH_RVER: begin
                if (si.vidx == VER_N) s = hdr_start(si);
                else begin
                    s.ferr = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_DONE;
                end
            end
            hlfv_pkg::PH_REASON: begin
                s = hdr_start(si);
                s.stok = 1'b1;
            end
            hlfv_pkg::PH_KEY: begin
                if (si.tlen == 11'd0) s.phase = hlfv_pkg::PH_BODY;
                else begin
                    s.ferr = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_DONE;
                end
            end
            hlfv_pkg::PH_VALUE: begin
                if (si.t2len >= {1'b0, k.value_cap}) begin
                    s.ferr = hlfv_pkg::V_LONG; s.phase = hlfv_pkg::PH_DONE;
                end else if (si.nul) begin
                    s.ferr = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_DONE;
                end else begin
                    s = hdr_start(si);
                    if (si.nidx == hlfv_pkg::NAME_LEN && !si.lseen) s.lseen = 1'b1;
                    s.acc = si.acc + 6'd1;
                end
            end
            default: begin
                s.ferr = hlfv_pkg::V_MAL; s.phase = hlfv_pkg::PH_DONE;
            end
        endcase
        return s;
    endfunction

    hlfv_pkg::st_t s0, s1, s2, s3;
    logic [POS_W-1:0] rem, bs_use;
    logic [1:0]  verdict;
    logic [16:0] boff, blen;
    logic [9:0]  stat_out;

    assign q_ready = !out_valid_reg || m_tready;
    assign take    = q_valid && q_ready;

    always_comb begin
        s0 = st_reg;
        if (st_reg.phase == hlfv_pkg::PH_START) begin
            s0.kind  = q_item.mode;
            s0.phase = q_item.mode ? hlfv_pkg::PH_SVER : hlfv_pkg::PH_METHOD;
            s0.vidx  = 5'd0;
        end
        pos_next = (pos_reg <= POS_LIMIT) ? pos_reg + POS_W'(1) : pos_reg;

        // a CR held from the previous byte either closes the line or is content
        s1 = s0;
        s2 = s0;
        if (line_ph(s0)) begin
            s1.prev_cr = 1'b0;
            if (s0.prev_cr && q_item.cls.is_lf) begin
                s1 = line_end(s1, cfg);
                s2 = s1;
            end else begin
                if (s0.prev_cr) s1 = content(s1, hlfv_pkg::CLS_CR, cfg);
                s2 = s1;
                if (q_item.cls.is_cr) s2.prev_cr = 1'b1;
                else s2 = content(s1, q_item.cls, cfg);
            end
        end
        s3 = s2;
        if (q_item.last && line_ph(s2) && s2.prev_cr) begin
            s3.prev_cr = 1'b0;
            s3 = content(s3, hlfv_pkg::CLS_CR, cfg);
        end

        bs_use = (s3.phase == hlfv_pkg::PH_BODY && st_reg.phase != hlfv_pkg::PH_BODY)
                 ? pos_next : bs_reg;
        rem    = pos_next - bs_use;
        boff   = 17'd0;
        blen   = 17'd0;
        priority if (pos_next > POS_LIMIT) verdict = hlfv_pkg::V_LONG;
        else if (s3.phase == hlfv_pkg::PH_DONE) verdict = s3.ferr;
        else if (s3.phase != hlfv_pkg::PH_BODY) verdict = hlfv_pkg::V_MAL;
        else if (!s3.lseen) verdict = (rem != '0) ? hlfv_pkg::V_LEN : hlfv_pkg::V_OK;
        else if (s3.dbad || s3.ddig == 6'd0 || s3.ddig > 6'd32) verdict = hlfv_pkg::V_MAL;
        else if (33'(s3.dlen) != 33'(rem)) verdict = hlfv_pkg::V_LEN;
        else verdict = hlfv_pkg::V_OK;
        if (verdict == hlfv_pkg::V_OK && s3.phase == hlfv_pkg::PH_BODY
            && !(pos_next > POS_LIMIT)) begin
            boff = 17'(bs_use);
            if (s3.lseen) blen = 17'(rem);
        end
        stat_out = (s3.kind && s3.stok) ? s3.stat : 10'd0;

        st_next        = st_reg;
        bs_next        = bs_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (take) begin
            if (q_item.last) begin
                st_next        = hlfv_pkg::ST_CLEAR;
                bs_next        = '0;
                out_valid_next = 1'b1;
                out_data_next  = {4'd0, stat_out, blen, boff, s3.acc, verdict};
            end else begin
                st_next = s3;
                bs_next = bs_use;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= hlfv_pkg::ST_CLEAR;
            pos_reg       <= '0;
            bs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            bs_reg        <= bs_next;
            out_valid_reg <= out_valid_next;
            if (take) pos_reg <= q_item.last ? '0 : pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !take) else $error("item taken while result stalled");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LIMIT + POS_W'(1)) else $error("byte position overran");
    a_body_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == hlfv_pkg::PH_BODY) |-> (bs_reg <= pos_reg))
        else $error("body start past position");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_item.last) |=> (st_reg.phase == hlfv_pkg::PH_START && pos_reg == '0))
        else $error("frame state not cleared");

endmodule
